/* src/ssdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdf_pkg
// Shared types, constants and the segment table of the display formatter.
// ----------------------------------------------------------------------------
package ssdf_pkg;

   // Display geometry
   localparam int DIGIT_COUNT = 8;
   localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int CUR_W = ($clog2(DIGIT_COUNT + 1) > 4) ? $clog2(DIGIT_COUNT + 1) : 4;

   // Operation codes
   localparam logic [1:0] OP_NUMBER  = 2'd0;
   localparam logic [1:0] OP_CHAR    = 2'd1;
   localparam logic [1:0] OP_REFRESH = 2'd2;

   // Symbol codes
   localparam logic [6:0] CODE_H     = 7'd17;
   localparam logic [6:0] CODE_L     = 7'd18;
   localparam logic [6:0] CODE_MINUS = 7'd20;
   localparam logic [6:0] CODE_BLANK = 7'd21;
   localparam logic [6:0] CODE_ZERO  = 7'd0;

   // Register map: index is paddr[3:2]
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_WRITE_LOCK   = 2'd0;
   localparam logic [1:0] REG_COMMAND_BASE = 2'd1;
   localparam logic [1:0] REG_TABLE_DECODE = 2'd2;

   localparam logic       RST_WRITE_LOCK   = 1'b0;
   localparam logic [7:0] RST_COMMAND_BASE = 8'd128;
   localparam logic       RST_TABLE_DECODE = 1'b1;

   // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP_TEN) >> 35
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  start_pos;
      logic [3:0]  max_len;
      logic [31:0] number;
      logic        blank_leading;
      logic [7:0]  text_char;
      logic        first_char;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] command_word;
      logic        last_word;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic             load_number;
      logic             digit_wr;
      logic             pad_wr;
      logic             char_op;
      logic             out_load;
      logic             out_last;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] word_idx;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic quot_zero;
      logic out_free;
   } dp_status_type;

   // Segment table for symbol codes 0..31
   function automatic logic [7:0] seg_lookup(input logic [4:0] code);
      logic [7:0] seg;
      unique case (code)
         5'd0:  seg = 8'h7E;
         5'd1:  seg = 8'h30;
         5'd2:  seg = 8'h6D;
         5'd3:  seg = 8'h79;
         5'd4:  seg = 8'h33;
         5'd5:  seg = 8'h5B;
         5'd6:  seg = 8'h5F;
         5'd7:  seg = 8'h70;
         5'd8:  seg = 8'h7f;
         5'd9:  seg = 8'h7B;
         5'd10: seg = 8'h77;
         5'd11: seg = 8'h7F;
         5'd12: seg = 8'h4E;
         5'd13: seg = 8'h7E;
         5'd14: seg = 8'h4F;
         5'd15: seg = 8'h47;
         5'd16: seg = 8'h7B;
         5'd17: seg = 8'h37;
         5'd18: seg = 8'h0E;
         5'd19: seg = 8'h77;
         5'd20: seg = 8'h01;
         5'd21: seg = 8'h00;
         5'd22: seg = 8'h1F;
         5'd23: seg = 8'h3D;
         5'd24: seg = 8'h3E;
         5'd25: seg = 8'h0F;
         5'd26: seg = 8'h15;
         5'd27: seg = 8'h1D;
         5'd28: seg = 8'h67;
         5'd29: seg = 8'h76;
         5'd30: seg = 8'h0D;
         5'd31: seg = 8'hFF;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

/* src/ssdf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdf_ctrl
// Sequencer: accepts items, steps number conversion and refresh word output.
// ----------------------------------------------------------------------------
module ssdf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssdf_pkg::req_payload_type req_data,
   input  logic                     write_lock,
   input  ssdf_pkg::dp_status_type  status,
   output ssdf_pkg::dp_cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIGIT,
      S_PAD,
      S_REFRESH
   } state_type;

   state_type                    state_ff, state_in;
   logic [ssdf_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [ssdf_pkg::POS_W-1:0]   idx_ff, idx_in;
   logic [3:0]                   used_ff, used_in;
   logic [3:0]                   len_ff, len_in;
   logic                         accept;
   logic [4:0]                   used_next;
   logic                         more;
   logic                         pos_zero;
   logic                         end_ok;
   logic                         idx_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign used_next = {1'b0, used_ff} + 5'd1;
   assign more      = (used_next < {1'b0, len_ff});
   assign pos_zero  = (pos_ff == '0);
   assign end_ok    = (req_data.start_pos != 4'd0) &&
                      (5'(req_data.start_pos) <= 5'(ssdf_pkg::DIGIT_COUNT));
   assign idx_last  = (idx_ff == ssdf_pkg::POS_W'(ssdf_pkg::DIGIT_COUNT - 1));

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      used_in  = used_ff;
      len_in   = len_ff;
      cmd      = '0;
      cmd.pos      = pos_ff;
      cmd.word_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_data.operation == ssdf_pkg::OP_NUMBER) begin
                  if (!write_lock && end_ok && req_data.max_len != 4'd0) begin
                     cmd.load_number = 1'b1;
                     pos_in   = ssdf_pkg::POS_W'(req_data.start_pos - 4'd1);
                     used_in  = 4'd0;
                     len_in   = req_data.max_len;
                     state_in = S_DIGIT;
                  end
               end else if (req_data.operation == ssdf_pkg::OP_CHAR) begin
                  cmd.char_op = !write_lock;
               end else if (req_data.operation == ssdf_pkg::OP_REFRESH) begin
                  idx_in   = '0;
                  state_in = S_REFRESH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIGIT: begin
            // write one digit, then step left, pad or finish
            cmd.digit_wr = 1'b1;
            used_in      = used_next[3:0];
            if (pos_zero || status.quot_zero) begin
               if (more && !pos_zero) begin
                  pos_in   = pos_ff - ssdf_pkg::POS_W'(1);
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               pos_in   = pos_ff - ssdf_pkg::POS_W'(1);
               state_in = more ? S_DIGIT : S_IDLE;
            end
         end
         S_PAD: begin
            cmd.pad_wr = 1'b1;
            used_in    = used_next[3:0];
            if (more && !pos_zero) begin
               pos_in = pos_ff - ssdf_pkg::POS_W'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_REFRESH: begin
            // one word per free output slot
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = idx_last;
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + ssdf_pkg::POS_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         idx_ff   <= '0;
         used_ff  <= 4'd0;
         len_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
         used_ff  <= used_in;
         len_ff   <= len_in;
      end
   end

endmodule

/* src/ssdf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdf_datapath
// Digit buffer, divide-by-ten unit, string cursor and output register.
// ----------------------------------------------------------------------------
module ssdf_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ssdf_pkg::req_payload_type req_data,
   input  ssdf_pkg::dp_cmd_type      cmd,
   output ssdf_pkg::dp_status_type   status,
   input  logic [7:0]                command_base,
   input  logic                      table_decode,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssdf_pkg::rsp_payload_type rsp_data
);

   localparam int DC    = ssdf_pkg::DIGIT_COUNT;
   localparam int POS_W = ssdf_pkg::POS_W;
   localparam int CUR_W = ssdf_pkg::CUR_W;

   // Buffer: symbol code per position, point bits kept apart
   logic [6:0]        code_ff [DC];
   logic [DC-1:0]     point_ff;

   logic [31:0]       value_ff;
   logic              blank_ff;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [CUR_W-1:0]  offset_ff, offset_in;
   logic [3:0]        taken_ff, taken_in;

   logic              rsp_valid_ff;
   ssdf_pkg::rsp_payload_type rsp_data_ff;

   // Divide by ten
   logic [63:0]       product;
   logic [31:0]       quot;
   logic [31:0]       quot_x10;
   logic [31:0]       rem_full;

   // Buffer write port and point set
   logic              wr_en;
   logic [POS_W-1:0]  wr_idx;
   logic [6:0]        wr_code;
   logic              wr_point;
   logic              pt_set;
   logic [POS_W-1:0]  pt_idx;

   // Character step
   logic [CUR_W-1:0]  cur_eff;
   logic [CUR_W-1:0]  off_eff;
   logic [3:0]        tk_eff;
   logic              full;
   logic [7:0]        mapped;

   // Refresh word
   logic [6:0]        rd_code;
   logic              rd_point;
   logic [7:0]        seg_byte;
   logic [15:0]       word;
   logic              out_free;

   function automatic logic [7:0] map_char(input logic [7:0] c);
      logic [7:0] d;
      priority if (c == 8'h20 || c == 8'h00 || c == 8'h2B) begin
         d = {1'b0, ssdf_pkg::CODE_BLANK};
      end else if (c == 8'h2D) begin
         d = {1'b0, ssdf_pkg::CODE_MINUS};
      end else if (c == 8'h48) begin
         d = {1'b0, ssdf_pkg::CODE_H};
      end else if (c == 8'h4C) begin
         d = {1'b0, ssdf_pkg::CODE_L};
      end else begin
         d = c - 8'h30;
      end
      return d;
   endfunction

   // Quotient and remainder of the working value
   assign product  = {32'd0, value_ff} * {32'd0, ssdf_pkg::RECIP_TEN};
   assign quot     = 32'(product[63:ssdf_pkg::RECIP_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem_full = value_ff - quot_x10;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.quot_zero = (quot == 32'd0);
   assign status.out_free  = out_free;

   // Effective string state for this character
   assign off_eff = req_data.first_char ? CUR_W'(req_data.start_pos) : offset_ff;
   assign cur_eff = req_data.first_char ? CUR_W'(req_data.start_pos) : cursor_ff;
   assign tk_eff  = req_data.first_char ? 4'd0 : taken_ff;
   assign full    = (tk_eff >= req_data.max_len) ||
                    ((CUR_W + 1)'(cur_eff) >= (CUR_W + 1)'(DC));
   assign mapped  = map_char(req_data.text_char);

   // Select the buffer write for this cycle
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = cmd.pos;
      wr_code   = ssdf_pkg::CODE_ZERO;
      wr_point  = 1'b0;
      pt_set    = 1'b0;
      pt_idx    = cur_eff[POS_W-1:0];
      cursor_in = cursor_ff;
      offset_in = offset_ff;
      taken_in  = taken_ff;
      if (cmd.digit_wr) begin
         wr_en   = 1'b1;
         wr_code = 7'(rem_full[3:0]);
      end else if (cmd.pad_wr) begin
         wr_en   = 1'b1;
         wr_code = blank_ff ? ssdf_pkg::CODE_BLANK : ssdf_pkg::CODE_ZERO;
      end else if (cmd.char_op) begin
         offset_in = off_eff;
         cursor_in = cur_eff;
         taken_in  = tk_eff;
         if (!full) begin
            wr_idx = cur_eff[POS_W-1:0];
            if (req_data.text_char == 8'h2E) begin
               if (cur_eff == off_eff) begin
                  // leading point: zero with point
                  wr_en     = 1'b1;
                  wr_code   = ssdf_pkg::CODE_ZERO;
                  wr_point  = 1'b1;
                  cursor_in = cur_eff + CUR_W'(1);
               end else begin
                  // merge into previous position
                  pt_set = 1'b1;
                  pt_idx = (cur_eff > off_eff) ? POS_W'(cur_eff - CUR_W'(1))
                                               : off_eff[POS_W-1:0];
               end
            end else begin
               wr_en     = 1'b1;
               wr_code   = mapped[6:0];
               wr_point  = mapped[7];
               cursor_in = cur_eff + CUR_W'(1);
            end
            taken_in = (tk_eff < 4'd15) ? tk_eff + 4'd1 : tk_eff;
         end
      end
   end

   // Hold buffer and string state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DC; i++) begin
            code_ff[i] <= 7'd0;
         end
         point_ff  <= '0;
         cursor_ff <= '0;
         offset_ff <= '0;
         taken_ff  <= 4'd0;
      end else begin
         if (wr_en) begin
            code_ff[wr_idx]  <= wr_code;
            point_ff[wr_idx] <= wr_point;
         end
         if (pt_set) begin
            point_ff[pt_idx] <= 1'b1;
         end
         cursor_ff <= cursor_in;
         offset_ff <= offset_in;
         taken_ff  <= taken_in;
      end
   end

   // Load or advance the working value
   always_ff @(posedge clock) begin
      if (cmd.load_number) begin
         value_ff <= req_data.number;
         blank_ff <= req_data.blank_leading;
      end else if (cmd.digit_wr) begin
         value_ff <= quot;
      end
   end

   // Form the refresh word
   assign rd_code  = code_ff[cmd.word_idx];
   assign rd_point = point_ff[cmd.word_idx];
   assign seg_byte = (rd_code[6:5] == 2'b00) ? ssdf_pkg::seg_lookup(rd_code[4:0])
                                             : ssdf_pkg::seg_lookup(ssdf_pkg::CODE_BLANK[4:0]);
   always_comb begin
      word[15:8] = command_base | 8'(cmd.word_idx);
      if (table_decode) begin
         word[7:0] = seg_byte | {rd_point, 7'd0};
      end else begin
         word[7:0] = {rd_point, rd_code};
      end
   end

   // Output register: drop a beat when taken, load a new one
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.command_word <= word;
         rsp_data_ff.last_word    <= cmd.out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/seven_segment_display_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_formatter
// Eight-digit display buffer with number, string and refresh operations.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_stall   req_payload_type
//  rsp_      out        rsp_valid/rsp_stall   rsp_payload_type
//  csr       in/out     psel/penable/pready   3 registers at 4*i
//
//  A character item is handled in the idle state. A number item writes one
//  position per cycle (digits then pads, at most DIGIT_COUNT), paced by the
//  single divide-by-ten unit. A refresh sends DIGIT_COUNT words, one per
//  cycle while the output is not stalled, through the single output register.
//  Reset clears the buffer and string cursor and loads register defaults.
//  A stalled output holds its word; the sequencer waits for the slot.
// ----------------------------------------------------------------------------
module seven_segment_display_formatter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ssdf_pkg::req_payload_type     req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ssdf_pkg::rsp_payload_type     rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ssdf_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic                    write_lock_ff;
   logic [7:0]              command_base_ff;
   logic                    table_decode_ff;
   logic                    csr_write;
   logic [1:0]              csr_index;
   ssdf_pkg::dp_cmd_type    cmd;
   ssdf_pkg::dp_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         write_lock_ff   <= ssdf_pkg::RST_WRITE_LOCK;
         command_base_ff <= ssdf_pkg::RST_COMMAND_BASE;
         table_decode_ff <= ssdf_pkg::RST_TABLE_DECODE;
      end else if (csr_write) begin
         unique case (csr_index)
            ssdf_pkg::REG_WRITE_LOCK:   write_lock_ff   <= pwdata[0];
            ssdf_pkg::REG_COMMAND_BASE: command_base_ff <= pwdata[7:0];
            ssdf_pkg::REG_TABLE_DECODE: table_decode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         ssdf_pkg::REG_WRITE_LOCK:   prdata = {31'd0, write_lock_ff};
         ssdf_pkg::REG_COMMAND_BASE: prdata = {24'd0, command_base_ff};
         ssdf_pkg::REG_TABLE_DECODE: prdata = {31'd0, table_decode_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   ssdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .write_lock (write_lock_ff),
      .status     (status),
      .cmd        (cmd)
   );

   ssdf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .command_base (command_base_ff),
      .table_decode (table_decode_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

/* verif/tb_seven_segment_display_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_display_formatter
// Drives number, string and refresh beats into the display formatter and
// checks every refresh word against a scoreboard that keeps its own copy of
// the digit buffer, the string cursor and the three control registers.
// Directed beats cover the field extremes and the corner cases. Random beats
// follow, mostly well-formed strings and numbers, under several register
// settings with random idling on both channels.
// ----------------------------------------------------------------------------

// Characters with a meaning of their own in the string operation
localparam logic [7:0] CH_POINT = 8'h2E;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_NUL   = 8'h00;
localparam logic [7:0] CH_PLUS  = 8'h2B;
localparam logic [7:0] CH_MINUS = 8'h2D;
localparam logic [7:0] CH_UPPER_H = 8'h48;
localparam logic [7:0] CH_UPPER_L = 8'h4C;
localparam logic [7:0] CH_ZERO  = 8'h30;
localparam logic [7:0] POINT_BIT = 8'h80;

class display_scoreboard;
   logic [7:0]      digits [ssdf_pkg::DIGIT_COUNT];
   logic [7:0]      segment_map [32];
   logic [3:0]      cursor;
   logic [3:0]      offset;
   logic [3:0]      taken;
   logic            write_lock;
   logic [7:0]      command_base;
   logic            table_decode;
   ssdf_pkg::rsp_payload_type expected_words [$];
   int              errors;
   int              words_checked;
   int              op_count [4];

   function new();
      foreach (digits[i]) digits[i] = 8'h00;
      cursor = '0;
      offset = '0;
      taken = '0;
      write_lock = ssdf_pkg::RST_WRITE_LOCK;
      command_base = ssdf_pkg::RST_COMMAND_BASE;
      table_decode = ssdf_pkg::RST_TABLE_DECODE;
      segment_map = '{8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
                      8'h7F, 8'h7B, 8'h77, 8'h7F, 8'h4E, 8'h7E, 8'h4F, 8'h47,
                      8'h7B, 8'h37, 8'h0E, 8'h77, 8'h01, 8'h00, 8'h1F, 8'h3D,
                      8'h3E, 8'h0F, 8'h15, 8'h1D, 8'h67, 8'h76, 8'h0D, 8'hFF};
      errors = 0;
      words_checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
   endfunction

   function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
         ssdf_pkg::REG_WRITE_LOCK: begin
            write_lock = value[0];
         end
         ssdf_pkg::REG_COMMAND_BASE: begin
            command_base = value[7:0];
         end
         ssdf_pkg::REG_TABLE_DECODE: begin
            table_decode = value[0];
         end
         default: begin
         end
      endcase
   endfunction

   // Write digits right-aligned from the end position, then pad leftward
   function void put_number(int unsigned endp, int unsigned len, logic [31:0] value,
                            logic blank);
      int unsigned pos;
      int unsigned used;
      logic [31:0] rest;
      if (endp == 0 || endp > ssdf_pkg::DIGIT_COUNT) return;
      pos = endp - 1;
      used = 0;
      rest = value;
      while (used < len) begin
         digits[pos] = 8'(rest % 10);
         rest = rest / 10;
         used++;
         if (pos == 0 || rest == 0) break;
         pos--;
      end
      while (used < len && pos > 0) begin
         pos--;
         digits[pos] = blank ? {1'b0, ssdf_pkg::CODE_BLANK} : {1'b0, ssdf_pkg::CODE_ZERO};
         used++;
      end
   endfunction

   // Place one character of a string; a point merges into the digit before it
   function void put_char(logic [7:0] ch, int unsigned len);
      int unsigned n;
      logic [7:0] code;
      n = cursor;
      if (taken >= len || n >= ssdf_pkg::DIGIT_COUNT) return;
      if (ch == CH_POINT) begin
         if (n == offset) begin
            digits[n] = POINT_BIT;
            n++;
         end else if (n > offset) begin
            digits[n-1] = digits[n-1] | POINT_BIT;
         end else begin
            digits[offset] = digits[offset] | POINT_BIT;
         end
      end else begin
         if (ch == CH_SPACE || ch == CH_NUL || ch == CH_PLUS)
            code = {1'b0, ssdf_pkg::CODE_BLANK};
         else if (ch == CH_MINUS) code = {1'b0, ssdf_pkg::CODE_MINUS};
         else if (ch == CH_UPPER_H) code = {1'b0, ssdf_pkg::CODE_H};
         else if (ch == CH_UPPER_L) code = {1'b0, ssdf_pkg::CODE_L};
         else code = ch - CH_ZERO;
         digits[n] = code;
         n++;
      end
      cursor = 4'(n);
      if (taken != 4'hF) taken++;
   endfunction

   // Note an accepted beat; a refresh queues one word per digit
   function void note_request(ssdf_pkg::req_payload_type item);
      ssdf_pkg::rsp_payload_type word;
      logic [7:0] b;
      op_count[item.operation]++;
      case (item.operation)
         ssdf_pkg::OP_NUMBER: begin
            if (!write_lock)
               put_number(item.start_pos, item.max_len, item.number, item.blank_leading);
         end
         ssdf_pkg::OP_CHAR: begin
            if (!write_lock) begin
               if (item.first_char) begin
                  offset = item.start_pos;
                  cursor = item.start_pos;
                  taken = '0;
               end
               put_char(item.text_char, item.max_len);
            end
         end
         ssdf_pkg::OP_REFRESH: begin
            for (int m = 0; m < ssdf_pkg::DIGIT_COUNT; m++) begin
               b = digits[m];
               word.command_word[15:8] = command_base | 8'(m);
               if (table_decode)
                  word.command_word[7:0] =
                     (b[6:5] == 2'b00 ? segment_map[b[4:0]]
                                      : segment_map[ssdf_pkg::CODE_BLANK[4:0]])
                     | (b & POINT_BIT);
               else
                  word.command_word[7:0] = b;
               word.last_word = (m == ssdf_pkg::DIGIT_COUNT - 1);
               expected_words.push_back(word);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function void check_word(ssdf_pkg::rsp_payload_type got);
      ssdf_pkg::rsp_payload_type want;
      if (expected_words.size() == 0) begin
         $error("command_word %h arrived with no word expected", got.command_word);
         errors++;
         return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.command_word !== want.command_word) begin
         $error("command_word: expected %h, actual %h", want.command_word, got.command_word);
         errors++;
      end
      if (got.last_word !== want.last_word) begin
         $error("last_word: expected %b, actual %b", want.last_word, got.last_word);
         errors++;
      end
   endfunction

   function int pending();
      return expected_words.size();
   endfunction
endclass

module tb_seven_segment_display_formatter;
   localparam int CYCLE_LIMIT = 300000;
   // A number beat writes one position per cycle; leave room after it
   localparam int SETTLE_CYCLES = 3 * ssdf_pkg::DIGIT_COUNT;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 67;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   ssdf_pkg::req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   ssdf_pkg::rsp_payload_type rsp_data;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [ssdf_pkg::ADDR_W-1:0] paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;

   display_scoreboard board;
   int              idle_pct;
   int              cycles;
   int              str_left;
   logic [3:0]      str_start;
   logic [3:0]      str_len;

   seven_segment_display_formatter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, board.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
   end

   // Check each accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_data);
   end

   function automatic ssdf_pkg::req_payload_type number_item(int sp, int len,
                                                             logic [31:0] value,
                                                             logic blank);
      ssdf_pkg::req_payload_type item;
      item = '0;
      item.operation = ssdf_pkg::OP_NUMBER;
      item.start_pos = 4'(sp);
      item.max_len = 4'(len);
      item.number = value;
      item.blank_leading = blank;
      return item;
   endfunction

   function automatic ssdf_pkg::req_payload_type char_item(logic first, int sp, int len,
                                                           logic [7:0] ch);
      ssdf_pkg::req_payload_type item;
      item = '0;
      item.operation = ssdf_pkg::OP_CHAR;
      item.first_char = first;
      item.start_pos = 4'(sp);
      item.max_len = 4'(len);
      item.text_char = ch;
      return item;
   endfunction

   function automatic ssdf_pkg::req_payload_type refresh_item();
      ssdf_pkg::req_payload_type item;
      item = '0;
      item.operation = ssdf_pkg::OP_REFRESH;
      return item;
   endfunction

   // Mostly well-formed numbers and strings, some refreshes, some noise
   function automatic ssdf_pkg::req_payload_type random_item();
      ssdf_pkg::req_payload_type item;
      int pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 10) begin
         item.operation = 2'($urandom_range(3));
         item.start_pos = 4'($urandom_range(15));
         item.max_len = 4'($urandom_range(15));
         item.number = $urandom;
         item.blank_leading = 1'($urandom_range(1));
         item.text_char = 8'($urandom_range(255));
         item.first_char = 1'($urandom_range(1));
      end else if (pick < 45) begin
         item = number_item($urandom_range(1, ssdf_pkg::DIGIT_COUNT),
                            $urandom_range(1, ssdf_pkg::DIGIT_COUNT),
                            $urandom >> $urandom_range(31), 1'($urandom_range(1)));
      end else if (pick < 85) begin
         case ($urandom_range(9))
            0, 1, 2, 3: ch = CH_ZERO + 8'($urandom_range(9));
            4:          ch = CH_POINT;
            5:          ch = CH_MINUS;
            6:          ch = $urandom_range(1) ? CH_UPPER_H : CH_UPPER_L;
            7:          ch = $urandom_range(1) ? CH_SPACE : ($urandom_range(1) ? CH_PLUS : CH_NUL);
            default:    ch = 8'($urandom_range(255));
         endcase
         if (str_left == 0) begin
            str_start = 4'($urandom_range(ssdf_pkg::DIGIT_COUNT - 1));
            str_len = 4'($urandom_range(1, ssdf_pkg::DIGIT_COUNT));
            str_left = $urandom_range(1, 10);
            item = char_item(1'b1, str_start, str_len, ch);
         end else begin
            item = char_item(1'b0, str_start, str_len, ch);
         end
         str_left--;
      end else begin
         item = refresh_item();
      end
      return item;
   endfunction

   // Present one beat, with random idle cycles ahead of it
   task automatic send_item(input ssdf_pkg::req_payload_type item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(index, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Wait out all expected words plus the tail of a number beat
   task automatic settle();
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input logic lock, input logic [7:0] base, input logic decode);
      req_valid <= 1'b0;
      settle();
      write_register(ssdf_pkg::REG_WRITE_LOCK, {31'd0, lock});
      write_register(ssdf_pkg::REG_COMMAND_BASE, {24'd0, base});
      write_register(ssdf_pkg::REG_TABLE_DECODE, {31'd0, decode});
   endtask

   initial begin
      logic [7:0] opening_text [9];
      ssdf_pkg::req_payload_type odd_op;
      opening_text = '{CH_POINT, CH_MINUS, CH_UPPER_H, CH_UPPER_L, CH_POINT, CH_SPACE,
                       CH_NUL, CH_PLUS, 8'h41};
      board = new();
      cycles = 0;
      idle_pct = 18;
      str_left = 0;
      str_start = '0;
      str_len = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings
      send_item(refresh_item());
      send_item(number_item(8, 8, 32'hFFFF_FFFF, 1'b0));
      send_item(number_item(4, 8, 32'd0, 1'b1));
      send_item(number_item(8, 3, 32'd7, 1'b0));
      send_item(number_item(0, 8, 32'd123, 1'b0));
      send_item(number_item(9, 8, 32'd456, 1'b1));
      send_item(number_item(15, 15, 32'd789, 1'b1));
      send_item(number_item(2, 0, 32'd5, 1'b0));
      send_item(number_item(1, 15, 32'd99, 1'b1));
      send_item(refresh_item());
      // Leading point, special characters, then one past the length
      for (int i = 0; i < 9; i++) send_item(char_item(i == 0, 0, 8, opening_text[i]));
      send_item(refresh_item());
      // Run off the right end, then an out-of-table code with a point
      send_item(char_item(1'b1, 6, 15, CH_ZERO + 8'd5));
      send_item(char_item(1'b0, 6, 15, CH_POINT));
      send_item(char_item(1'b0, 6, 15, 8'h7A));
      send_item(char_item(1'b0, 6, 15, CH_ZERO + 8'd7));
      send_item(char_item(1'b1, 3, 4, 8'h21));
      odd_op = '1;
      send_item(odd_op);
      send_item(refresh_item());

      // Locked, raw bytes, zero command base
      apply_setting(1'b1, 8'h00, 1'b0);
      send_item(number_item(8, 8, 32'd1234, 1'b0));
      send_item(char_item(1'b1, 0, 8, CH_ZERO + 8'd7));
      send_item(refresh_item());

      // Random beats under a range of settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_setting(1'b0, 8'h80, 1'b1);
            1: apply_setting(1'b0, 8'hFF, 1'b0);
            2: apply_setting(1'b0, 8'($urandom_range(255)), 1'b1);
            3: apply_setting(1'b1, 8'($urandom_range(255)), 1'b1);
            4: apply_setting(1'b0, 8'h00, 1'b1);
            default: apply_setting(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
         endcase
         idle_pct = (p == 2) ? 0 : 18;
         repeat (PHASE_BEATS) send_item(random_item());
      end

      req_valid <= 1'b0;
      settle();
      $display("beats: %0d number, %0d string, %0d refresh, %0d unused op",
               board.op_count[ssdf_pkg::OP_NUMBER], board.op_count[ssdf_pkg::OP_CHAR],
               board.op_count[ssdf_pkg::OP_REFRESH], board.op_count[3]);
      $display("display words checked: %0d, mismatches: %0d", board.words_checked, board.errors);
      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
